// File: rtl/dpem_pkg.sv
package dpem_pkg;

  localparam int MaxPrimers     = 8;
  localparam int MaxPrimerLen   = 32;
  localparam int PrimerMemDepth = MaxPrimers * MaxPrimerLen;

  localparam int SlotW  = 3;
  localparam int PosW   = 5;
  localparam int SymW   = 8;
  localparam int LenW   = 6;
  localparam int CountW = 16;
  localparam int NumW   = 4;
  localparam int CfgW   = 4;
  localparam int CfgIdxW = 1;

  // Item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindBase = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPrimerCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMatchAtEnd  = 1'b1;

  // Base and IUPAC code characters
  localparam logic [SymW-1:0] ChA = 8'h41;
  localparam logic [SymW-1:0] ChC = 8'h43;
  localparam logic [SymW-1:0] ChG = 8'h47;
  localparam logic [SymW-1:0] ChT = 8'h54;
  localparam logic [SymW-1:0] ChR = 8'h52;
  localparam logic [SymW-1:0] ChY = 8'h59;
  localparam logic [SymW-1:0] ChM = 8'h4D;
  localparam logic [SymW-1:0] ChK = 8'h4B;
  localparam logic [SymW-1:0] ChW = 8'h57;
  localparam logic [SymW-1:0] ChS = 8'h53;
  localparam logic [SymW-1:0] ChB = 8'h42;
  localparam logic [SymW-1:0] ChD = 8'h44;
  localparam logic [SymW-1:0] ChH = 8'h48;
  localparam logic [SymW-1:0] ChV = 8'h56;
  localparam logic [SymW-1:0] ChN = 8'h4E;
  localparam logic [SymW-1:0] ChI = 8'h49;

endpackage

// File: rtl/degenerate_primer_end_matcher_top.sv
// Degenerate primer matcher: load requests (kind 0) write one primer character each and
// read bases (kind 1) are taken one per cycle; both are accepted only while the block
// is idle. The last base of a read starts a search that walks the primer table in slot
// order through one shared IUPAC compare unit fed by the single read port of the primer
// memory: each slot visited takes a slot check, each character compared a read step and
// a compare step, and a final step posts the result; input ready stays low meanwhile.
// The result sits in an output register; loads and bases are accepted again while it
// waits, and a following search holds its result until the register frees up. Primer
// count values above eight search eight slots.
module degenerate_primer_end_matcher_top
  import dpem_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic [SlotW-1:0]   in_slot_i,
  input  logic [PosW-1:0]    in_position_i,
  input  logic [SymW-1:0]    in_symbol_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_matched_o,
  output logic [SlotW-1:0]   out_primer_index_o,
  output logic [LenW-1:0]    out_primer_length_o,
  output logic [CountW-1:0]  out_read_length_o,
  output logic [CountW-1:0]  out_kept_length_o,
  output logic               out_short_read_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [NumW-1:0]    slot_q, slot_d;
  logic [PosW-1:0]    char_q, char_d;
  logic [CountW-1:0]  base_cnt_q, base_cnt_d;
  logic [PosW-1:0]    wp_q, wp_d;
  logic [NumW-1:0]    prim_cnt_q, prim_cnt_d;
  logic               mode_q, mode_d;
  logic [LenW-1:0]    plen_q [MaxPrimers];
  logic [LenW-1:0]    plen_d [MaxPrimers];

  logic               res_matched_q, res_matched_d;
  logic               res_short_q, res_short_d;
  logic [SlotW-1:0]   res_index_q, res_index_d;
  logic [LenW-1:0]    res_plen_q, res_plen_d;

  logic               out_valid_q, out_valid_d;
  logic               out_matched_q, out_matched_d;
  logic [SlotW-1:0]   out_index_q, out_index_d;
  logic [LenW-1:0]    out_plen_q, out_plen_d;
  logic [CountW-1:0]  out_rlen_q, out_rlen_d;
  logic [CountW-1:0]  out_klen_q, out_klen_d;
  logic               out_short_q, out_short_d;

  logic               in_acc;
  logic               load_ok;
  logic [NumW-1:0]    cnt_eff;
  logic [LenW-1:0]    cur_len;
  logic               prim_we;
  logic               win_we;
  logic [PosW-1:0]    win_waddr;
  logic [PosW-1:0]    win_raddr;
  logic [SymW-1:0]    prim_char;
  logic [SymW-1:0]    win_char;
  logic               hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_ok    = (NumW'(in_slot_i) < NumW'(MaxPrimers))
                   && (LenW'(in_position_i) < LenW'(MaxPrimerLen));
  assign cnt_eff    = (prim_cnt_q > NumW'(MaxPrimers)) ? NumW'(MaxPrimers) : prim_cnt_q;
  assign cur_len    = plen_q[slot_q[SlotW-1:0]];

  assign prim_we   = in_acc && (in_kind_i == KindLoad) && load_ok;
  assign win_we    = in_acc && (in_kind_i == KindBase)
                  && (mode_q || (base_cnt_q < CountW'(MaxPrimerLen)));
  assign win_waddr = mode_q ? wp_q : base_cnt_q[PosW-1:0];
  // Suffix mode: the window ends just before the write pointer
  assign win_raddr = mode_q ? (wp_q - cur_len[PosW-1:0] + char_q) : char_q;

  dpem_char_mem #(
    .Depth (PrimerMemDepth)
  ) u_primer_mem (
    .clk_i   (clk_i),
    .we_i    (prim_we),
    .waddr_i ({in_slot_i, in_position_i}),
    .wdata_i (in_symbol_i),
    .raddr_i ({slot_q[SlotW-1:0], char_q}),
    .rdata_o (prim_char)
  );

  dpem_char_mem #(
    .Depth (MaxPrimerLen)
  ) u_window_mem (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (in_symbol_i),
    .raddr_i (win_raddr),
    .rdata_o (win_char)
  );

  dpem_code_match u_code_match (
    .pattern_i (prim_char),
    .base_i    (win_char),
    .hit_o     (hit)
  );

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    char_d        = char_q;
    base_cnt_d    = base_cnt_q;
    wp_d          = wp_q;
    prim_cnt_d    = prim_cnt_q;
    mode_d        = mode_q;
    plen_d        = plen_q;
    res_matched_d = res_matched_q;
    res_short_d   = res_short_q;
    res_index_d   = res_index_q;
    res_plen_d    = res_plen_q;
    out_valid_d   = out_valid_q;
    out_matched_d = out_matched_q;
    out_index_d   = out_index_q;
    out_plen_d    = out_plen_q;
    out_rlen_d    = out_rlen_q;
    out_klen_d    = out_klen_q;
    out_short_d   = out_short_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPrimerCount: prim_cnt_d = cfg_data_i[NumW-1:0];
        RegMatchAtEnd:  mode_d     = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind_i == KindLoad) begin
            if (load_ok && in_last_i) begin
              plen_d[in_slot_i] = LenW'(in_position_i) + LenW'(1);
            end
          end else begin
            if (mode_q) begin
              wp_d = wp_q + PosW'(1);
            end
            if (base_cnt_q != '1) begin
              base_cnt_d = base_cnt_q + CountW'(1);
            end
            if (in_last_i) begin
              slot_d  = '0;
              state_d = S_SLOT;
            end
          end
        end
      end
      S_SLOT: begin
        res_matched_d = 1'b0;
        res_short_d   = 1'b0;
        res_index_d   = '0;
        res_plen_d    = '0;
        if (slot_q >= cnt_eff) begin
          state_d = S_DONE;
        end else if (base_cnt_q < CountW'(cur_len)) begin
          res_short_d = 1'b1;
          state_d     = S_DONE;
        end else if (cur_len == '0) begin
          // Empty primer matches every read
          res_matched_d = 1'b1;
          res_index_d   = slot_q[SlotW-1:0];
          state_d       = S_DONE;
        end else begin
          char_d  = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!hit) begin
          slot_d  = slot_q + NumW'(1);
          state_d = S_SLOT;
        end else if (char_q == PosW'(cur_len - LenW'(1))) begin
          res_matched_d = 1'b1;
          res_index_d   = slot_q[SlotW-1:0];
          res_plen_d    = cur_len;
          state_d       = S_DONE;
        end else begin
          char_d  = char_q + PosW'(1);
          state_d = S_READ;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_matched_d = res_matched_q;
          out_index_d   = res_index_q;
          out_plen_d    = res_plen_q;
          out_short_d   = res_short_q;
          out_rlen_d    = base_cnt_q;
          out_klen_d    = base_cnt_q - CountW'(res_plen_q);
          base_cnt_d    = '0;
          wp_d          = '0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_q        <= '0;
      char_q        <= '0;
      base_cnt_q    <= '0;
      wp_q          <= '0;
      prim_cnt_q    <= '0;
      mode_q        <= 1'b0;
      for (int i = 0; i < MaxPrimers; i++) begin
        plen_q[i] <= '0;
      end
      res_matched_q <= 1'b0;
      res_short_q   <= 1'b0;
      res_index_q   <= '0;
      res_plen_q    <= '0;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_index_q   <= '0;
      out_plen_q    <= '0;
      out_rlen_q    <= '0;
      out_klen_q    <= '0;
      out_short_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      slot_q        <= slot_d;
      char_q        <= char_d;
      base_cnt_q    <= base_cnt_d;
      wp_q          <= wp_d;
      prim_cnt_q    <= prim_cnt_d;
      mode_q        <= mode_d;
      plen_q        <= plen_d;
      res_matched_q <= res_matched_d;
      res_short_q   <= res_short_d;
      res_index_q   <= res_index_d;
      res_plen_q    <= res_plen_d;
      out_valid_q   <= out_valid_d;
      out_matched_q <= out_matched_d;
      out_index_q   <= out_index_d;
      out_plen_q    <= out_plen_d;
      out_rlen_q    <= out_rlen_d;
      out_klen_q    <= out_klen_d;
      out_short_q   <= out_short_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_matched_o       = out_matched_q;
  assign out_primer_index_o  = out_index_q;
  assign out_primer_length_o = out_plen_q;
  assign out_read_length_o   = out_rlen_q;
  assign out_kept_length_o   = out_klen_q;
  assign out_short_read_o    = out_short_q;

  a_result_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result posted without a finished search");

  a_match_short_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_matched_o && out_short_read_o))
    else $error("result both matched and short");

  a_kept_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kept_length_o + CountW'(out_primer_length_o) == out_read_length_o))
    else $error("kept length does not add up");

  a_char_in_primer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (LenW'(char_q) < cur_len))
    else $error("compare beyond primer end");

endmodule

// File: rtl/dpem_char_mem.sv
module dpem_char_mem
  import dpem_pkg::*;
#(
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [SymW-1:0]  wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [SymW-1:0]  rdata_o
);

  logic [SymW-1:0] mem_q [Depth];
  logic [SymW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dpem_code_match.sv
module dpem_code_match
  import dpem_pkg::*;
(
  input  logic [SymW-1:0] pattern_i,
  input  logic [SymW-1:0] base_i,
  output logic            hit_o
);

  always_comb begin
    if (pattern_i == base_i) begin
      hit_o = 1'b1;
    end else begin
      case (pattern_i)
        ChA, ChC, ChG, ChT: hit_o = 1'b0;
        ChN, ChI:           hit_o = (base_i != ChN);
        ChR:                hit_o = base_i inside {ChA, ChG};
        ChY:                hit_o = base_i inside {ChC, ChT};
        ChM:                hit_o = base_i inside {ChA, ChC};
        ChK:                hit_o = base_i inside {ChG, ChT};
        ChW:                hit_o = base_i inside {ChA, ChT};
        ChS:                hit_o = base_i inside {ChC, ChG};
        ChB:                hit_o = base_i inside {ChC, ChG, ChT};
        ChD:                hit_o = base_i inside {ChA, ChG, ChT};
        ChH:                hit_o = base_i inside {ChA, ChC, ChT};
        ChV:                hit_o = base_i inside {ChA, ChC, ChG};
        default:            hit_o = 1'b1;
      endcase
    end
  end

endmodule
